### rtl/core/acm_pkg.sv
// Shared types, constants and arctangent table for the arctangent contrast map.
// No dependencies.
`default_nettype none
package acm_pkg;
    localparam int AtanStagesDef = 16;
    localparam int AtanMax = 24;
    localparam logic signed [31:0] InvPiQ30 = 32'sd341782638;

    typedef enum logic [2:0] {
        REG_MEAN = 3'd0, REG_DEV = 3'd1, REG_MIN = 3'd2,
        REG_MAX = 3'd3, REG_BIAS = 3'd4, REG_GRAD = 3'd5
    } t_reg_idx;

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0: atan_q30 = 30'd843314857;
            5'd1: atan_q30 = 30'd497837830;
            5'd2: atan_q30 = 30'd263043837;
            5'd3: atan_q30 = 30'd133525159;
            5'd4: atan_q30 = 30'd67021687;
            5'd5: atan_q30 = 30'd33543516;
            5'd6: atan_q30 = 30'd16775851;
            5'd7: atan_q30 = 30'd8388437;
            5'd8: atan_q30 = 30'd4194283;
            5'd9: atan_q30 = 30'd2097149;
            default: atan_q30 = 30'd1 << (5'd30 - i);
        endcase
    endfunction
endpackage
`default_nettype wire

### rtl/core/acm_div.sv
// Pipelined restoring divider: signed dividend over positive divisor, truncating.
// Depends on acm_pkg. One quotient bit per stage, with a sign fix-up stage.
`default_nettype none
module acm_div import acm_pkg::*; #(
    parameter int NW = 48,
    parameter int DW = 24,
    parameter int TW = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic signed [NW-1:0] i_num,
    input  wire logic [DW-1:0]        i_den,
    input  wire logic [TW-1:0]        i_tag,
    output logic signed [NW-1:0]      o_quo,
    output logic [TW-1:0]             o_tag
);
    // Stage 0 takes magnitude; stages 1..NW each produce one bit; last stage applies sign.
    logic [NW-1:0] r_q   [NW+1];
    logic [DW:0]   r_rem [NW+1];
    logic [DW-1:0] r_den [NW+1];
    logic          r_neg [NW+1];
    logic [TW-1:0] r_tag [NW+1];
    logic signed [NW-1:0] r_out;
    logic [TW-1:0] r_otag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
            r_otag   <= '0;
        end else if (i_en) begin
            r_tag[0] <= i_tag;
            r_otag   <= r_tag[NW];
        end
        if (i_en) begin
            r_q[0]   <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r_rem[0] <= '0;
            r_den[0] <= (i_den == '0) ? DW'(1) : i_den;
            r_neg[0] <= i_num[NW-1];
            r_out    <= r_neg[NW] ? -$signed(r_q[NW]) : $signed(r_q[NW]);
        end
    end

    for (genvar k = 0; k < NW; k++) begin : g_st
        logic [DW+1:0] trial;
        logic [DW+1:0] sh;
        assign sh    = {r_rem[k], r_q[k][NW-1]};
        assign trial = sh - {2'b00, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k+1] <= '0;
            end else if (i_en) begin
                r_tag[k+1] <= r_tag[k];
            end
            if (i_en) begin
                r_q[k+1]   <= {r_q[k][NW-2:0], ~trial[DW+1]};
                r_rem[k+1] <= trial[DW+1] ? sh[DW:0] : trial[DW:0];
                r_den[k+1] <= r_den[k];
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    assign o_quo = r_out;
    assign o_tag = r_otag;
endmodule
`default_nettype wire

### rtl/core/acm_cordic.sv
// Pipelined vectoring CORDIC giving the arctangent in Q.16 radians.
// Depends on acm_pkg for the angle table.
`default_nettype none
module acm_cordic import acm_pkg::*; #(
    parameter int STAGES = AtanStagesDef,
    parameter int TW = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic signed [41:0] i_u,
    input  wire logic [TW-1:0]      i_tag,
    output logic signed [17:0]      o_theta,
    output logic [TW-1:0]           o_tag
);
    localparam int N = (STAGES < AtanMax) ? STAGES : AtanMax;
    logic signed [51:0] r_x [N+1];
    logic signed [51:0] r_y [N+1];
    logic signed [32:0] r_a [N+1];
    logic [TW-1:0]      r_t [N+1];
    logic signed [32:0] rnd;
    logic signed [17:0] r_th;
    logic [TW-1:0]      r_ot;

    assign rnd = r_a[N] + 33'sd8192;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t[0] <= '0;
            r_ot   <= '0;
        end else if (i_en) begin
            r_t[0] <= i_tag;
            r_ot   <= r_t[N];
        end
        if (i_en) begin
            r_x[0] <= 52'sd16777216;
            r_y[0] <= {{2{i_u[41]}}, i_u, 8'd0};
            r_a[0] <= '0;
            r_th   <= rnd[31:14];
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_st
        logic signed [32:0] ang;
        assign ang = $signed({3'b000, atan_q30(5'(i))});
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_t[i+1] <= '0;
            end else if (i_en) begin
                r_t[i+1] <= r_t[i];
            end
            if (i_en) begin
                if (!r_y[i][51]) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_a[i+1] <= r_a[i] + ang;
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_a[i+1] <= r_a[i] - ang;
                end
            end
        end
    end

    assign o_theta = r_th;
    assign o_tag   = r_ot;
endmodule
`default_nettype wire

### rtl/core/arctan_contrast_map_top.sv
// Top level of the arctangent contrast map: registers, two dividers, CORDIC, scaling.
// Depends on acm_pkg, acm_div and acm_cordic.
`default_nettype none
// While the output is not stalled, one voxel beat enters per clock and one
// result beat leaves per clock. The block is a single pipeline with one shared
// enable: every stage advances when the output register is empty or being
// taken, so a stall at the output freezes the whole pipe and nothing is lost or
// repeated. A voxel passes through one input stage, 50 stages for the 48-bit
// deviation quotient, one bias stage, 58 stages for the 56-bit gradient quotient,
// one clamp stage, ATAN_STAGES+2 CORDIC stages (ATAN_STAGES capped at AtanMax)
// and four scaling and saturation stages. The two bit-per-stage dividers make up
// most of the pipeline depth. The input stalls exactly when the output stalls a
// valid beat: while the result register holds an untaken beat, no voxel is taken.
// Configuration registers must only be written while the pipe is empty.
module arctan_contrast_map_top import acm_pkg::*; #(
    parameter int ATAN_STAGES = AtanStagesDef
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_pixel_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [15:0]      o_result_value,
    output logic                    o_clipped,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data
);
    logic signed [23:0] r_mean;
    logic [23:0]        r_dev;
    logic signed [15:0] r_min, r_max, r_bias;
    logic [15:0]        r_grad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= '0; r_dev <= 24'd256; r_min <= '0;
            r_max <= '0; r_bias <= '0; r_grad <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MEAN: r_mean <= i_cfg_data;
                REG_DEV:  r_dev  <= i_cfg_data;
                REG_MIN:  r_min  <= i_cfg_data[15:0];
                REG_MAX:  r_max  <= i_cfg_data[15:0];
                REG_BIAS: r_bias <= i_cfg_data[15:0];
                REG_GRAD: r_grad <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together; valid travels as the tag bit.
    logic en;
    logic r_ovalid;
    assign en      = !r_ovalid || !i_stall;
    assign o_stall = !en;

    // First stage: d = v*256 - mean, scaled by 2^16.
    logic signed [25:0] d;
    logic signed [47:0] r_num1;
    logic               r_v1;
    assign d = $signed({i_pixel_value, 8'd0}) - 26'(r_mean);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (en) r_v1 <= i_valid;
        if (en) r_num1 <= {{6{d[25]}}, d, 16'd0};
    end

    logic signed [47:0] z;
    logic [0:0] t_z;
    acm_div #(.NW(48), .DW(24), .TW(1)) u_div_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_num(r_num1), .i_den(r_dev),
        .i_tag(r_v1), .o_quo(z), .o_tag(t_z)
    );

    // w = z - bias*256, then times 256 for the gradient quotient.
    logic signed [47:0] w;
    logic signed [55:0] r_num2;
    logic               r_v2;
    assign w = z - 48'($signed({r_bias, 8'd0}));
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (en) r_v2 <= t_z[0];
        if (en) r_num2 <= {w, 8'd0};
    end

    logic signed [55:0] u;
    logic [0:0] t_u;
    acm_div #(.NW(56), .DW(16), .TW(1)) u_div_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_num(r_num2), .i_den(r_grad),
        .i_tag(r_v2), .o_quo(u), .o_tag(t_u)
    );

    // Clamp to +-2^40, beyond which atan is pi/2 at Q.16. The positive limit
    // needs 42 bits signed.
    logic signed [41:0] r_uc;
    logic               r_v3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (en) r_v3 <= t_u[0];
        if (en) begin
            if (u > 56'sd1099511627776)       r_uc <= 42'sd1099511627776;
            else if (u < -56'sd1099511627776) r_uc <= -42'sd1099511627776;
            else                              r_uc <= u[41:0];
        end
    end

    logic signed [17:0] theta;
    logic [0:0] t_th;
    acm_cordic #(.STAGES(ATAN_STAGES), .TW(1)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_u(r_uc), .i_tag(r_v3),
        .o_theta(theta), .o_tag(t_th)
    );

    // Scaling: theta*range, then *inv_pi, plus mean*2^38, round, saturate.
    logic signed [17:0] range;
    logic signed [34:0] r_p1;
    logic signed [66:0] r_s;
    logic signed [20:0] r_r;
    logic               r_v4, r_v5, r_v6;
    logic signed [66:0] sum;
    assign range = 18'(r_max) - 18'(r_min);
    assign sum = 67'(r_p1) * InvPiQ30 + ($signed({{5{r_mean[23]}}, r_mean, 38'd0}))
                 + (67'sd1 <<< 45);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0; r_v5 <= 1'b0; r_v6 <= 1'b0; r_ovalid <= 1'b0;
        end else if (en) begin
            r_v4 <= t_th[0]; r_v5 <= r_v4; r_v6 <= r_v5; r_ovalid <= r_v6;
        end
        if (en) begin
            r_p1 <= 35'(theta) * 35'(range);
            r_s  <= sum;
            r_r  <= r_s[66:46];
            if (r_r > 21'sd32767) begin
                o_result_value <= 16'sh7fff; o_clipped <= 1'b1;
            end else if (r_r < -21'sd32768) begin
                o_result_value <= -16'sh8000; o_clipped <= 1'b1;
            end else begin
                o_result_value <= r_r[15:0]; o_clipped <= 1'b0;
            end
        end
    end
    assign o_valid = r_ovalid;
endmodule
`default_nettype wire

### rtl/core/acm_checker.sv
// Port-level checker for the arctangent contrast map, bound to the top level.
// Depends on arctan_contrast_map_top ports only.
`default_nettype none
module acm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [15:0] o_result_value,
    input wire logic        o_clipped
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_value)) else $error("held");
    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall) else $error("stall");
    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clipped |-> o_result_value == 16'h7fff || o_result_value == 16'h8000)
        else $error("clip");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid) else $error("rst");
endmodule
bind arctan_contrast_map_top acm_checker u_acm_checker (.*);
`default_nettype wire
